// File: sv/dtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared types and constants of the dispersion tensor datapath.
// ----------------------------------------------------------------------------
package dtc_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 32;
  localparam int unsigned NumW      = 96;
  localparam int unsigned DvsW      = 48;

  localparam logic [1:0] REG_MOL = 2'd0;
  localparam logic [1:0] REG_LON = 2'd1;
  localparam logic [1:0] REG_LAT = 2'd2;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  // Beat in flight through the root chain.
  typedef struct packed {
    logic                  vld;
    logic [63:0]           v;
    logic [63:0]           r;
    logic [5:0][NumW-1:0]  num;
    logic [31:0]           mol;
  } dtc_sq_t;

  // One quotient lane of the divider chain.
  typedef struct packed {
    logic [DvsW-1:0] rem;
    logic [31:0]     low;
    logic [31:0]     quo;
    logic            sat;
  } dtc_lane_t;

  // Beat in flight through the divider chain.
  typedef struct packed {
    logic                  vld;
    dtc_lane_t [5:0]       lane;
    logic [DvsW-1:0]       dvs;
    logic [31:0]           mol;
    logic                  zero;
  } dtc_div_t;

endpackage

// File: sv/dispersion_tensor_cell.sv
`timescale 1ns / 1ps
// Pipeline: 6 front stages, 32 root cells, 1 divisor setup stage, 32 divider
// cells and 1 output register lie between input beat and result beat.
// Throughput: one beat per cycle; the root and divider chains advance one step
// per cell per cycle and the whole pipeline holds while a result beat stalls.
// Reset: synchronous active-low rst_n clears all valid bits and the three
// coefficient registers to zero.
// ----------------------------------------------------------------------------
// dispersion_tensor_cell
// Bear-Scheidegger dispersion tensor of one grid cell in fixed point.
// ----------------------------------------------------------------------------
module dispersion_tensor_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // flux_x [31:0], flux_y [63:32], flux_z [95:64], water_content [111:96]
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // disp_xx [31:0], disp_yy [63:32], disp_zz [95:64],
  // disp_xy [127:96], disp_xz [159:128], disp_yz [191:160]
  output logic [191:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0] coef_mol_r, alpha_l_r, alpha_t_r;
  logic        en;

  dtc_pkg::dtc_sq_t  sq_c [0:dtc_pkg::SqrtSteps];
  dtc_pkg::dtc_div_t dv_c [0:dtc_pkg::DivSteps];
  dtc_pkg::dtc_div_t cv_r, cv_nxt;
  dtc_pkg::dtc_div_t dl;

  logic         out_vld_r;
  logic [191:0] out_data_r, out_data_nxt;
  logic [47:0]  dvs;
  logic [32:0]  dsum;
  logic [31:0]  qv;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_mol_r <= 32'd0;
      alpha_l_r  <= 32'd0;
      alpha_t_r  <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dtc_pkg::REG_MOL: coef_mol_r <= cfg_wdata;
        dtc_pkg::REG_LON: alpha_l_r  <= cfg_wdata;
        dtc_pkg::REG_LAT: alpha_t_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dtc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_tvalid),
    .flux     ({in_tdata[95:64], in_tdata[63:32], in_tdata[31:0]}),
    .water    (in_tdata[111:96]),
    .coef_mol (coef_mol_r),
    .alpha_l  (alpha_l_r),
    .alpha_t  (alpha_t_r),
    .sq_o     (sq_c[0])
  );

  for (genvar k = 0; k < dtc_pkg::SqrtSteps; k++) begin : g_sqrt
    dtc_sqrt_cell #(.STEP(k)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sq_i  (sq_c[k]),
      .sq_o  (sq_c[k + 1])
    );
  end

  // Set up the divisor Q * 2^16 and flag quotients that overflow 32 bits.
  always_comb begin
    dvs         = {sq_c[dtc_pkg::SqrtSteps].r[31:0], 16'd0};
    cv_nxt.vld  = sq_c[dtc_pkg::SqrtSteps].vld;
    cv_nxt.dvs  = dvs;
    cv_nxt.mol  = sq_c[dtc_pkg::SqrtSteps].mol;
    cv_nxt.zero = sq_c[dtc_pkg::SqrtSteps].r[31:0] == 32'd0;
    for (int i = 0; i < 6; i++) begin
      cv_nxt.lane[i].sat = sq_c[dtc_pkg::SqrtSteps].num[i][95:32] >= {16'd0, dvs};
      cv_nxt.lane[i].rem = sq_c[dtc_pkg::SqrtSteps].num[i][79:32];
      cv_nxt.lane[i].low = sq_c[dtc_pkg::SqrtSteps].num[i][31:0];
      cv_nxt.lane[i].quo = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r.vld <= 1'b0;
    else if (en) cv_r <= cv_nxt;
  end

  assign dv_c[0] = cv_r;

  for (genvar k = 0; k < dtc_pkg::DivSteps; k++) begin : g_div
    dtc_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .dv_i  (dv_c[k]),
      .dv_o  (dv_c[k + 1])
    );
  end

  assign dl = dv_c[dtc_pkg::DivSteps];

  always_comb begin
    out_data_nxt = '0;
    dsum         = '0;
    qv           = '0;
    for (int i = 0; i < 6; i++) begin
      qv = dl.lane[i].sat ? dtc_pkg::MAX32 : dl.lane[i].quo;
      if (i < 3) begin
        dsum = {1'b0, dl.mol} + {1'b0, qv};
        if (dl.zero) out_data_nxt[i*32 +: 32] = dl.mol;
        else out_data_nxt[i*32 +: 32] = dsum[32] ? dtc_pkg::MAX32 : dsum[31:0];
      end else begin
        out_data_nxt[i*32 +: 32] = dl.zero ? 32'd0 : qv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r  <= dl.vld;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_ready_tracks_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output register state");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    sq_c[dtc_pkg::SqrtSteps].vld |-> sq_c[dtc_pkg::SqrtSteps].r[63:32] == 32'd0)
    else $error("square root exceeds 32 bits");

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    (dl.vld && !dl.zero && !dl.lane[0].sat) |-> dl.lane[0].rem < dl.dvs)
    else $error("divider remainder not below divisor");

  a_zero_flux: assert property (@(posedge clk) disable iff (!rst_n)
    (en && dl.vld && dl.zero) |=>
      (out_tdata[191:96] == 96'd0 && out_tdata[31:0] == out_tdata[63:32]
       && out_tdata[63:32] == out_tdata[95:64]))
    else $error("zero flux result not purely molecular");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

// File: sv/dtc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_front
// Six-stage front end: magnitudes, squares, sums and tensor numerators.
// ----------------------------------------------------------------------------
module dtc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2:0][31:0] flux,
  input  logic [15:0]      water,
  input  logic [31:0]      coef_mol,
  input  logic [31:0]      alpha_l,
  input  logic [31:0]      alpha_t,
  output dtc_pkg::dtc_sq_t sq_o
);

  // stage 1
  logic             f1_vld_r;
  logic [2:0][31:0] f1_mag_r, f1_mag_nxt;
  logic [2:0]       f1_neg_r;
  logic [15:0]      f1_w_r;
  // stage 2
  logic             f2_vld_r;
  logic [2:0][63:0] f2_sq_r, f2_sq_nxt;
  logic [2:0][63:0] f2_pr_r, f2_pr_nxt;
  logic [2:0]       f2_offz_r, f2_offz_nxt;
  logic [31:0]      f2_mol_r;
  logic [47:0]      mol_prod;
  logic [31:0]      dmag_r;
  logic             dneg_r;
  // stage 3
  logic             f3_vld_r;
  logic [63:0]      f3_s_r;
  logic [2:0][63:0] f3_sq_r, f3_t_r, f3_t_nxt, f3_pr_r;
  logic [2:0]       f3_offz_r;
  logic [31:0]      f3_mol_r;
  // stage 4
  logic             f4_vld_r;
  logic [63:0]      f4_s_r;
  logic [2:0][63:0] f4_pllo_r, f4_plhi_r, f4_ptlo_r, f4_pthi_r, f4_polo_r, f4_pohi_r;
  logic [2:0][63:0] f4_pllo_nxt, f4_plhi_nxt, f4_ptlo_nxt, f4_pthi_nxt;
  logic [2:0][63:0] f4_polo_nxt, f4_pohi_nxt;
  logic [2:0]       f4_offz_r;
  logic [31:0]      f4_mol_r;
  // stage 5
  logic             f5_vld_r;
  logic [63:0]      f5_s_r;
  logic [2:0][95:0] f5_ln_r, f5_tn_r, f5_on_r, f5_ln_nxt, f5_tn_nxt, f5_on_nxt;
  logic [31:0]      f5_mol_r;
  // stage 6
  dtc_pkg::dtc_sq_t f6_r, f6_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f1_mag_nxt[i] = flux[i][31] ? (~flux[i] + 32'd1) : flux[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2_sq_nxt[i] = f1_mag_r[i] * f1_mag_r[i];
    end
    f2_pr_nxt[0]   = f1_mag_r[0] * f1_mag_r[1];
    f2_pr_nxt[1]   = f1_mag_r[0] * f1_mag_r[2];
    f2_pr_nxt[2]   = f1_mag_r[1] * f1_mag_r[2];
    // a negative off-diagonal entry clamps to zero
    f2_offz_nxt[0] = dneg_r ^ f1_neg_r[0] ^ f1_neg_r[1];
    f2_offz_nxt[1] = dneg_r ^ f1_neg_r[0] ^ f1_neg_r[2];
    f2_offz_nxt[2] = dneg_r ^ f1_neg_r[1] ^ f1_neg_r[2];
    mol_prod       = coef_mol * f1_w_r;
  end

  always_comb begin
    f3_t_nxt[0] = f2_sq_r[1] + f2_sq_r[2];
    f3_t_nxt[1] = f2_sq_r[0] + f2_sq_r[2];
    f3_t_nxt[2] = f2_sq_r[0] + f2_sq_r[1];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f4_pllo_nxt[i] = alpha_l * f3_sq_r[i][31:0];
      f4_plhi_nxt[i] = alpha_l * f3_sq_r[i][63:32];
      f4_ptlo_nxt[i] = alpha_t * f3_t_r[i][31:0];
      f4_pthi_nxt[i] = alpha_t * f3_t_r[i][63:32];
      f4_polo_nxt[i] = dmag_r * f3_pr_r[i][31:0];
      f4_pohi_nxt[i] = dmag_r * f3_pr_r[i][63:32];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f5_ln_nxt[i] = {f4_plhi_r[i], 32'd0} + {32'd0, f4_pllo_r[i]};
      f5_tn_nxt[i] = {f4_pthi_r[i], 32'd0} + {32'd0, f4_ptlo_r[i]};
      f5_on_nxt[i] = f4_offz_r[i] ? 96'd0
                   : ({f4_pohi_r[i], 32'd0} + {32'd0, f4_polo_r[i]});
    end
  end

  always_comb begin
    f6_nxt.vld = f5_vld_r;
    f6_nxt.v   = f5_s_r;
    f6_nxt.r   = 64'd0;
    f6_nxt.mol = f5_mol_r;
    for (int i = 0; i < 3; i++) begin
      f6_nxt.num[i]     = f5_ln_r[i] + f5_tn_r[i];
      f6_nxt.num[i + 3] = f5_on_r[i];
    end
  end

  always_ff @(posedge clk) begin
    dneg_r <= alpha_l < alpha_t;
    dmag_r <= (alpha_l < alpha_t) ? (alpha_t - alpha_l) : (alpha_l - alpha_t);
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
      f3_vld_r <= 1'b0;
      f4_vld_r <= 1'b0;
      f5_vld_r <= 1'b0;
      f6_r.vld <= 1'b0;
    end else if (en) begin
      f1_vld_r  <= in_vld;
      f1_mag_r  <= f1_mag_nxt;
      f1_neg_r  <= {flux[2][31], flux[1][31], flux[0][31]};
      f1_w_r    <= water;
      f2_vld_r  <= f1_vld_r;
      f2_sq_r   <= f2_sq_nxt;
      f2_pr_r   <= f2_pr_nxt;
      f2_offz_r <= f2_offz_nxt;
      f2_mol_r  <= mol_prod[47:16];
      f3_vld_r  <= f2_vld_r;
      f3_s_r    <= f2_sq_r[0] + f2_sq_r[1] + f2_sq_r[2];
      f3_sq_r   <= f2_sq_r;
      f3_t_r    <= f3_t_nxt;
      f3_pr_r   <= f2_pr_r;
      f3_offz_r <= f2_offz_r;
      f3_mol_r  <= f2_mol_r;
      f4_vld_r  <= f3_vld_r;
      f4_s_r    <= f3_s_r;
      f4_pllo_r <= f4_pllo_nxt;
      f4_plhi_r <= f4_plhi_nxt;
      f4_ptlo_r <= f4_ptlo_nxt;
      f4_pthi_r <= f4_pthi_nxt;
      f4_polo_r <= f4_polo_nxt;
      f4_pohi_r <= f4_pohi_nxt;
      f4_offz_r <= f3_offz_r;
      f4_mol_r  <= f3_mol_r;
      f5_vld_r  <= f4_vld_r;
      f5_s_r    <= f4_s_r;
      f5_ln_r   <= f5_ln_nxt;
      f5_tn_r   <= f5_tn_nxt;
      f5_on_r   <= f5_on_nxt;
      f5_mol_r  <= f4_mol_r;
      f6_r      <= f6_nxt;
    end
  end

  assign sq_o = f6_r;

endmodule

// File: sv/dtc_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_sqrt_cell
// One step of the bitwise integer square root; hands the beat to the next cell.
// ----------------------------------------------------------------------------
module dtc_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  dtc_pkg::dtc_sq_t sq_i,
  output dtc_pkg::dtc_sq_t sq_o
);

  localparam logic [63:0] Bit = 64'd1 << (62 - 2 * STEP);

  dtc_pkg::dtc_sq_t sq_r, sq_nxt;
  logic [63:0]      trial;

  always_comb begin
    sq_nxt = sq_i;
    trial  = sq_i.r + Bit;
    if (sq_i.v >= trial) begin
      sq_nxt.v = sq_i.v - trial;
      sq_nxt.r = (sq_i.r >> 1) + Bit;
    end else begin
      sq_nxt.r = sq_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_r.vld <= 1'b0;
    else if (en) sq_r <= sq_nxt;
  end

  assign sq_o = sq_r;

endmodule

// File: sv/dtc_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_div_cell
// One restoring division step for all six tensor lanes.
// ----------------------------------------------------------------------------
module dtc_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  dtc_pkg::dtc_div_t dv_i,
  output dtc_pkg::dtc_div_t dv_o
);

  dtc_pkg::dtc_div_t          dv_r, dv_nxt;
  logic [5:0][dtc_pkg::DvsW:0] rem2;
  logic [5:0]                  ge;

  always_comb begin
    dv_nxt = dv_i;
    for (int i = 0; i < 6; i++) begin
      rem2[i] = {dv_i.lane[i].rem, dv_i.lane[i].low[31]};
      ge[i]   = rem2[i] >= {1'b0, dv_i.dvs};
      dv_nxt.lane[i].rem = ge[i] ? rem2[i][dtc_pkg::DvsW-1:0] - dv_i.dvs
                                 : rem2[i][dtc_pkg::DvsW-1:0];
      dv_nxt.lane[i].low = {dv_i.lane[i].low[30:0], 1'b0};
      dv_nxt.lane[i].quo = {dv_i.lane[i].quo[30:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r.vld <= 1'b0;
    else if (en) dv_r <= dv_nxt;
  end

  assign dv_o = dv_r;

endmodule

// File: tb/dtc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtc_checker
// Watches the flux and tensor streams of the dispersion tensor cell, tracks
// the coefficient writes, predicts each tensor beat and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module dtc_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [111:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [191:0] out_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  output int           errors,
  output int           pending
);

  logic [31:0] dm, alpha_l, alpha_t;
  logic [191:0] tensor_q[$];

  function automatic logic [31:0] sat32(logic [127:0] v);
    return (v > 128'hFFFF_FFFF) ? dtc_pkg::MAX32 : v[31:0];
  endfunction

  function automatic logic [31:0] isqrt(logic [65:0] s);
    logic [65:0] r;
    logic [65:0] b;
    r = 0;
    for (int i = 32; i >= 0; i--) begin
      b = r | (66'd1 << i);
      if (b * b <= s) r = b;
    end
    return r[31:0];
  endfunction

  function automatic logic [191:0] tensor_of(logic [111:0] d);
    logic [31:0] m[3];
    logic        n[3];
    logic [63:0] sq[3];
    logic [31:0] mol, q, dmag, res[6];
    logic [127:0] den, num;
    logic        dneg;
    int          a, b;
    for (int k = 0; k < 3; k++) begin
      n[k]  = d[32*k+31];
      m[k]  = n[k] ? -d[32*k +: 32] : d[32*k +: 32];
      sq[k] = 64'(m[k]) * 64'(m[k]);
    end
    mol = 32'((64'(dm) * 64'(d[111:96])) >> 16);
    q   = isqrt(66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]));
    if (q == 0) return {96'd0, mol, mol, mol};
    den  = 128'(q) << 16;
    dneg = alpha_l < alpha_t;
    dmag = dneg ? alpha_t - alpha_l : alpha_l - alpha_t;
    for (int k = 0; k < 3; k++) begin
      num = 128'(alpha_l) * sq[k] + 128'(alpha_t) * (128'(sq[(k+1)%3]) + sq[(k+2)%3]);
      res[k] = sat32(128'(mol) + sat32(num / den));
    end
    for (int k = 0; k < 3; k++) begin
      a = (k == 2) ? 1 : 0;
      b = (k == 0) ? 1 : 2;
      num = 128'(dmag) * 128'(m[a]) * 128'(m[b]);
      res[3+k] = (num == 0 || (dneg ^ n[a] ^ n[b])) ? 32'd0 : sat32(num / den);
    end
    return {res[5], res[4], res[3], res[2], res[1], res[0]};
  endfunction

  assign pending = tensor_q.size();

  always @(posedge clk) begin
    logic [191:0] want;
    int           bad;
    bad = 0;
    if (!rst_n) begin
      dm <= 0;
      alpha_l <= 0;
      alpha_t <= 0;
      errors <= 0;
      tensor_q.delete();
    end else begin
      if (in_tvalid && in_tready) tensor_q.push_back(tensor_of(in_tdata));
      if (out_tvalid && out_tready) begin
        if (tensor_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual %h", $time, out_tdata);
          bad = bad + 1;
        end else begin
          want = tensor_q.pop_front();
          for (int f = 0; f < 6; f++)
            if (want[32*f +: 32] !== out_tdata[32*f +: 32]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[32*f +: 32], out_tdata[32*f +: 32]);
              bad = bad + 1;
            end
        end
      end
      errors <= errors + bad;
      if (cfg_wr_en) begin
        case (cfg_index)
          dtc_pkg::REG_MOL: dm <= cfg_wdata;
          dtc_pkg::REG_LON: alpha_l <= cfg_wdata;
          dtc_pkg::REG_LAT: alpha_t <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives flux beats through the dispersion tensor cell under several
// coefficient settings with random idling and backpressure; the checker
// predicts and compares every tensor beat.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] RegUnused = 2'd3;

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0;
  logic [111:0] in_tdata = 0;
  logic [191:0] out_tdata;
  logic cfg_wr_en = 0;
  logic [1:0] cfg_index = dtc_pkg::REG_MOL;
  logic [31:0] cfg_wdata = 0;
  int errors, pending;
  int idle_pct = 29;
  logic hold_go = 0;
  logic long_hold = 0;

  always #1 clk = ~clk;

  dispersion_tensor_cell u_dut (.*);
  dtc_checker u_chk (.*);

  // Receiver: random stalls, plus one long hold when asked.
  always @(posedge clk) begin
    if (long_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Count the long receiver hold.
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  function automatic logic [31:0] pick_flux();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4: return $urandom_range(65536 * 4) - 65536 * 2;
      5: return $urandom_range(255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(logic [31:0] fx, fy, fz, logic [15:0] wc);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {wc, fz, fy, fx};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_coef(logic [1:0] idx, logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_beats(int count);
    for (int i = 0; i < count; i++)
      send_beat(pick_flux(), pick_flux(), pick_flux(),
                ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
  endtask

  initial begin
    logic [31:0] dmv, alv, atv;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Zero coefficients first: everything collapses to zero.
    send_beat(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 16'hFFFF);
    drain();
    write_coef(dtc_pkg::REG_MOL, 32'h0001_8000);
    write_coef(dtc_pkg::REG_LON, 32'h0000_4000);
    write_coef(dtc_pkg::REG_LAT, 32'h0000_1000);
    write_coef(RegUnused, 32'hDEAD_BEEF);
    send_beat(0, 0, 0, 16'hFFFF);
    send_beat(0, 0, 0, 0);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
    send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
    send_beat(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 16'h1234);
    send_beat(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 16'h4321);
    send_beat(1, 0, 0, 16'hFFFF);
    send_beat(0, 32'hFFFF_FFFF, 1, 16'h0001);
    send_beat(32'h0003_0000, 32'h0004_0000, 0, 16'hAAAA);
    drain();
    // Transverse above longitudinal flips off-diagonal signs; huge values saturate.
    write_coef(dtc_pkg::REG_LON, 32'h0000_0100);
    write_coef(dtc_pkg::REG_LAT, 32'hFFFF_FFFF);
    write_coef(dtc_pkg::REG_MOL, 32'hFFFF_FFFF);
    send_beat(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 16'hFFFF);
    send_beat(32'hFFFF_0000, 32'hFFFF_0000, 32'h0002_0000, 16'hFFFF);
    send_beat(1, 1, 1, 16'h5555);
    send_beat(32'h7FFF_FFFF, 1, 32'h8000_0000, 16'h0);
    drain();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin dmv = 0; alv = 32'hFFFF_FFFF; atv = 0; end
        1: begin dmv = 32'hFFFF_FFFF; alv = 0; atv = 32'hFFFF_FFFF; end
        2: begin dmv = 32'h0000_8000; alv = alv; atv = atv; alv = 32'h0002_0000;
                 atv = 32'h0000_2000; end
        default: begin dmv = $urandom; alv = $urandom_range(32'h40000);
                 atv = $urandom_range(32'h40000); end
      endcase
      write_coef(dtc_pkg::REG_MOL, dmv);
      write_coef(dtc_pkg::REG_LON, alv);
      write_coef(dtc_pkg::REG_LAT, atv);
      idle_pct = (phase == 4) ? 0 : 29;
      if (phase == 5) hold_go = 1'b1;
      random_beats(250);
      drain();
    end
    if (errors == 0) begin
      $display("[dispersion_tensor_cell] OK");
    end else begin
      $display("[dispersion_tensor_cell] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[dispersion_tensor_cell] ERROR");
    $finish;
  end
endmodule
